// File: hw/rtl/server_placement_weight_assert.svh
// Assertion macros used by the checker of the placement weight block.
// The macros expect signals named clk and arst_n in the scope where they are used.
`ifndef SERVER_PLACEMENT_WEIGHT_ASSERT_SVH
`define SERVER_PLACEMENT_WEIGHT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/spw_pkg.sv
// Shared types and constants of the server placement weight block.
// No dependencies; every other file of the block but the queue and the assertion macros uses it.
package spw_pkg;

	localparam int PCT_BITS = 14;
	localparam int NUM_BITS = 64;
	localparam int CFG_DATA_W = 50;
	localparam int CFG_INDEX_W = 3;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 32;

	localparam logic [PCT_BITS-1:0] PCT_FULL = 14'd10000;
	localparam logic [11:0] FIXED_LOAD_DIV = 12'd3000;
	localparam logic [3:0] LOAD_PEAK_MIN = 4'd10;
	localparam logic [6:0] W_ELECT = 7'd80;
	localparam logic [3:0] W_USE = 4'd15;
	localparam logic [2:0] W_LOAD = 3'd5;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_DEST = 2'd1;

	localparam logic [CFG_INDEX_W-1:0] CFG_ALIVE_COUNT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOAD_SUM = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY_SUM = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BLOCK_COUNT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOAD_PEAK = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_ELECT_NUM = 3'd5;

	typedef struct packed {
		logic [1:0] req_type;
		logic server_alive;
		logic server_full;
		logic [30:0] server_load;
		logic [49:0] server_used;
		logic [49:0] server_capacity;
		logic [30:0] server_blocks;
		logic [47:0] server_elections;
	} item_t;

	typedef struct packed {
		logic [47:0] weight;
		logic eligible;
	} result_t;

	typedef struct packed {
		logic [15:0] alive_count;
		logic [30:0] load_sum;
		logic [49:0] capacity_sum;
		logic [30:0] max_block_count;
		logic [30:0] load_peak;
		logic [47:0] total_elect_num;
	} cfg_t;

	// One percent figure waiting for division; ovr marks the cases settled without it.
	typedef struct packed {
		logic [49:0] v;
		logic [49:0] t;
		logic ovr;
		logic ovr_full;
	} lane_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic ok;
		logic [47:0] elect;
		lane_t elect_l;
		lane_t use_l;
		lane_t load_l;
	} cls_t;

	typedef struct packed {
		logic [NUM_BITS-1:0] r;
		logic [49:0] t;
		logic [PCT_BITS-1:0] q;
		logic ovr;
		logic ovr_full;
	} div_lane_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic ok;
		logic [47:0] elect;
		div_lane_t elect_l;
		div_lane_t use_l;
		div_lane_t load_l;
	} div_item_t;

endpackage

// File: hw/rtl/spw_queue.sv
// Small register queue used between the front and back parts and at the output.
// Depends on nothing but its parameters.
module spw_queue #(
	parameter int DEPTH = 4,
	parameter type T = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T din,
	input  logic pop,
	output T dout,
	output logic empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	T mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH-1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign dout = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

// File: hw/rtl/spw_front.sv
// Front part: takes a server record, forms the average-test products and
// classifies the record into eligibility and three percent lanes. Uses spw_pkg.
module spw_front (
	input  logic clk,
	input  logic arst_n,
	input  spw_pkg::cfg_t cfg,
	input  logic in_valid,
	input  spw_pkg::item_t in_item,
	output logic out_valid,
	output spw_pkg::cls_t out_cls,
	output logic [1:0] busy
);

	// Stage 1: the average tests become A*(floor(load/2)+1) <= TL and A*ceil(used/2) <= TC.
	logic valid_s1;
	spw_pkg::item_t item_s1;
	logic [46:0] p_load_s1;
	logic [65:0] p_used_s1;

	logic [30:0] half_load;
	logic [49:0] half_used;

	always_comb begin
		half_load = 31'(in_item.server_load >> 1) + 31'd1;
		half_used = 50'((51'(in_item.server_used) + 51'd1) >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			item_s1 <= in_item;
			p_load_s1 <= 47'(cfg.alive_count) * 47'(half_load);
			p_used_s1 <= 66'(cfg.alive_count) * 66'(half_used);
		end
	end

	// Stage 2: compares and lane setup.
	function automatic spw_pkg::lane_t make_lane(input logic [49:0] v, input logic [49:0] t);
		spw_pkg::lane_t l;
		l.v = v;
		l.t = t;
		l.ovr = (t == '0) || (v >= t);
		l.ovr_full = (t != '0) || (v != '0);
		return l;
	endfunction

	logic valid_s2;
	spw_pkg::cls_t cls_s2;
	spw_pkg::cls_t cls_d;
	logic load_ok;
	logic used_ok;
	logic [49:0] use_v;
	logic [49:0] use_t;
	logic [49:0] load_t;

	always_comb begin
		load_ok = (cfg.load_sum == '0) || (47'(cfg.load_sum) >= p_load_s1);
		used_ok = (cfg.capacity_sum == '0) || (66'(cfg.capacity_sum) >= p_used_s1);
		if (cfg.max_block_count == '0) begin
			use_v = item_s1.server_used;
			use_t = item_s1.server_capacity;
		end else begin
			use_v = 50'(item_s1.server_blocks);
			use_t = 50'(cfg.max_block_count);
		end
		if (cfg.load_peak < 31'(spw_pkg::LOAD_PEAK_MIN)) begin
			load_t = 50'(spw_pkg::FIXED_LOAD_DIV);
		end else begin
			load_t = 50'(cfg.load_peak);
		end
		cls_d.req_type = item_s1.req_type;
		cls_d.ok = item_s1.server_alive && (cfg.alive_count != '0) && !item_s1.server_full
			&& load_ok && used_ok;
		cls_d.elect = item_s1.server_elections;
		cls_d.elect_l = make_lane(50'(item_s1.server_elections), 50'(cfg.total_elect_num));
		cls_d.use_l = make_lane(use_v, use_t);
		cls_d.load_l = make_lane(50'(item_s1.server_load), load_t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			cls_s2 <= cls_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_cls = cls_s2;
	assign busy = {1'b0, valid_s1} + {1'b0, valid_s2};

endmodule

// File: hw/rtl/spw_back.sv
// Back part: three restoring dividers, one quotient bit per stage, then the
// weight blend. Never stalls; the caller limits what enters. Uses spw_pkg.
module spw_back (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  spw_pkg::cls_t in_cls,
	output logic out_valid,
	output spw_pkg::result_t out_res
);

	localparam int QB = spw_pkg::PCT_BITS;

	function automatic spw_pkg::div_lane_t start_lane(input spw_pkg::lane_t l);
		spw_pkg::div_lane_t d;
		d.r = spw_pkg::NUM_BITS'(l.v) * spw_pkg::NUM_BITS'(spw_pkg::PCT_FULL);
		d.t = l.t;
		d.q = '0;
		d.ovr = l.ovr;
		d.ovr_full = l.ovr_full;
		return d;
	endfunction

	function automatic spw_pkg::div_lane_t step_lane(input spw_pkg::div_lane_t l, input int k);
		spw_pkg::div_lane_t d;
		logic [spw_pkg::NUM_BITS-1:0] sub;
		d = l;
		sub = spw_pkg::NUM_BITS'(l.t) << k;
		if (l.r >= sub) begin
			d.r = l.r - sub;
			d.q = {l.q[QB-2:0], 1'b1};
		end else begin
			d.q = {l.q[QB-2:0], 1'b0};
		end
		return d;
	endfunction

	function automatic logic [QB-1:0] lane_pct(input spw_pkg::div_lane_t l);
		if (l.ovr) begin
			return l.ovr_full ? spw_pkg::PCT_FULL : '0;
		end
		return l.q;
	endfunction

	spw_pkg::div_item_t div_s [QB+1];
	logic div_vld_s [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else begin
			div_vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			div_s[0].req_type <= in_cls.req_type;
			div_s[0].ok <= in_cls.ok;
			div_s[0].elect <= in_cls.elect;
			div_s[0].elect_l <= start_lane(in_cls.elect_l);
			div_s[0].use_l <= start_lane(in_cls.use_l);
			div_s[0].load_l <= start_lane(in_cls.load_l);
		end
	end

	for (genvar i = 0; i < QB; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[i+1] <= 1'b0;
			end else begin
				div_vld_s[i+1] <= div_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (div_vld_s[i]) begin
				div_s[i+1].req_type <= div_s[i].req_type;
				div_s[i+1].ok <= div_s[i].ok;
				div_s[i+1].elect <= div_s[i].elect;
				div_s[i+1].elect_l <= step_lane(div_s[i].elect_l, QB-1-i);
				div_s[i+1].use_l <= step_lane(div_s[i].use_l, QB-1-i);
				div_s[i+1].load_l <= step_lane(div_s[i].load_l, QB-1-i);
			end
		end
	end

	spw_pkg::div_item_t last;
	logic [QB-1:0] e_pct;
	logic [QB-1:0] u_pct;
	logic [QB-1:0] l_pct;
	logic [19:0] blend;
	spw_pkg::result_t res_d;
	spw_pkg::result_t res_sf;
	logic res_vld_sf;

	always_comb begin
		last = div_s[QB];
		e_pct = lane_pct(last.elect_l);
		u_pct = lane_pct(last.use_l);
		l_pct = lane_pct(last.load_l);
		blend = 20'(e_pct) * 20'(spw_pkg::W_ELECT) + 20'(u_pct) * 20'(spw_pkg::W_USE)
			+ 20'(l_pct) * 20'(spw_pkg::W_LOAD);
		if (last.req_type == spw_pkg::REQ_WRITE) begin
			res_d.eligible = last.ok;
			res_d.weight = last.ok ? last.elect : '0;
		end else if (last.req_type == spw_pkg::REQ_DEST) begin
			res_d.eligible = last.ok;
			res_d.weight = last.ok ? 48'(blend) : '0;
		end else begin
			res_d.eligible = 1'b1;
			res_d.weight = 48'(l_pct);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_sf <= 1'b0;
		end else begin
			res_vld_sf <= div_vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (div_vld_s[QB]) begin
			res_sf <= res_d;
		end
	end

	assign out_valid = res_vld_sf;
	assign out_res = res_sf;

endmodule

// File: hw/rtl/server_placement_weight.sv
// Server placement weight: one server record in, one weight beat out.
// Accepts one beat per cycle while full is low. A beat passes, in order, through the
// two front stages, the middle queue, the divider entry stage, the
// 14-step divider pipeline, the blend stage and the output queue.
// Reset (arst_n low, asynchronous) empties all queues and clears the cluster registers.
module server_placement_weight #(
	parameter int QUEUE_DEPTH = spw_pkg::QUEUE_DEPTH_DEF,
	parameter int OUT_DEPTH = spw_pkg::OUT_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  spw_pkg::item_t item,
	output logic empty,
	input  logic pop,
	output spw_pkg::result_t result,
	input  logic cfg_we,
	input  logic [spw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [spw_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int QCW = $clog2(QUEUE_DEPTH+1);
	localparam int OCW = $clog2(OUT_DEPTH+1);

	// Cluster totals. The user must change them only while the block is idle; the
	// block does not enforce it. The pipeline reads them live, not a copy per beat.
	spw_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				spw_pkg::CFG_ALIVE_COUNT: cfg_q.alive_count <= cfg_data[15:0];
				spw_pkg::CFG_LOAD_SUM: cfg_q.load_sum <= cfg_data[30:0];
				spw_pkg::CFG_CAPACITY_SUM: cfg_q.capacity_sum <= cfg_data[49:0];
				spw_pkg::CFG_MAX_BLOCK_COUNT: cfg_q.max_block_count <= cfg_data[30:0];
				spw_pkg::CFG_LOAD_PEAK: cfg_q.load_peak <= cfg_data[30:0];
				spw_pkg::CFG_TOTAL_ELECT_NUM: cfg_q.total_elect_num <= cfg_data[47:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Front part. The front stages never stall, so the input side reserves
	// a queue slot for every beat still inside them: full counts those beats
	// together with what already waits in the middle queue.
	logic accept;
	logic front_valid;
	spw_pkg::cls_t front_cls;
	logic [1:0] front_busy;

	assign accept = push && !full;

	spw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(accept),
		.in_item(item),
		.out_valid(front_valid),
		.out_cls(front_cls),
		.busy(front_busy)
	);

	logic mid_empty;
	logic [QCW-1:0] mid_count;
	spw_pkg::cls_t mid_cls;
	logic pull;
	logic [QCW:0] mid_fill;

	spw_queue #(
		.DEPTH(QUEUE_DEPTH),
		.T(spw_pkg::cls_t)
	) u_mid_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(front_valid),
		.din(front_cls),
		.pop(pull),
		.dout(mid_cls),
		.empty(mid_empty),
		.count(mid_count)
	);

	always_comb begin
		mid_fill = (QCW+1)'(mid_count) + (QCW+1)'(front_busy);
		full = (mid_fill >= (QCW+1)'(QUEUE_DEPTH));
	end

	// Back part. The divider pipeline does not stall either; a beat leaves the
	// middle queue only when a slot of the output queue is reserved for it.
	// occ_q counts beats in the back pipeline plus beats in the output queue.
	logic [OCW-1:0] occ_q;
	logic out_pop;
	logic back_valid;
	spw_pkg::result_t back_res;
	logic [OCW-1:0] out_count;

	assign pull = !mid_empty && (occ_q < OCW'(OUT_DEPTH));
	assign out_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (pull && !out_pop) begin
			occ_q <= occ_q + 1'b1;
		end else if (out_pop && !pull) begin
			occ_q <= occ_q - 1'b1;
		end
	end

	spw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(pull),
		.in_cls(mid_cls),
		.out_valid(back_valid),
		.out_res(back_res)
	);

	// Output queue: finished beats wait here, so a stalled consumer never holds up the
	// divider pipeline; full rises only once this queue and the middle queue fill up.
	spw_queue #(
		.DEPTH(OUT_DEPTH),
		.T(spw_pkg::result_t)
	) u_out_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(back_valid),
		.din(back_res),
		.pop(out_pop),
		.dout(result),
		.empty(empty),
		.count(out_count)
	);

endmodule

// File: hw/rtl/spw_checker.sv
// Port-level checker for the server placement weight block, bound to the top level.
// Uses spw_pkg and the macros of server_placement_weight_assert.svh.
`include "server_placement_weight_assert.svh"

module spw_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic full,
	input  logic pop,
	input  logic empty,
	input  spw_pkg::result_t result
);

	// Beats accepted but not yet delivered.
	logic [7:0] pending_q;
	logic in_acc;
	logic out_acc;

	assign in_acc = push && !full;
	assign out_acc = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`SPW_ASSERT_IMP(a_no_invented, pending_q == '0, empty, "result shown with nothing pending")
	`SPW_ASSERT_IMP(a_ineligible_zero, !empty && !result.eligible, result.weight == '0,
		"ineligible result with nonzero weight")
	`SPW_ASSERT_NXT(a_hold_result, !empty && !pop, !empty && $stable(result),
		"waiting result changed")

endmodule

bind server_placement_weight spw_checker u_spw_checker (
	.clk(clk),
	.arst_n(arst_n),
	.push(push),
	.full(full),
	.pop(pop),
	.empty(empty),
	.result(result)
);

// File: tb/server_placement_weight_test.sv
// Testbench for the server placement weight block: directed and random server records.
// Depends on spw_pkg and server_placement_weight; a scoreboard class predicts each beat.
module server_placement_weight_test;
	timeunit 1ns;
	timeprecision 1ps;
	import spw_pkg::*;

	localparam logic [1:0] REQ_SOURCE = 2'd2;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	int error_count = 0;

	// Prints one line per mismatch and keeps the running count.
	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		error_count++;
	endtask

	// The scoreboard holds the cluster registers and the queue of predicted weights.
	class weight_scoreboard;
		cfg_t cluster;
		result_t predicted_q[$];

		function new();
			cluster = '0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_ALIVE_COUNT: cluster.alive_count = val[15:0];
				CFG_LOAD_SUM: cluster.load_sum = val[30:0];
				CFG_CAPACITY_SUM: cluster.capacity_sum = val[49:0];
				CFG_MAX_BLOCK_COUNT: cluster.max_block_count = val[30:0];
				CFG_LOAD_PEAK: cluster.load_peak = val[30:0];
				CFG_TOTAL_ELECT_NUM: cluster.total_elect_num = val[47:0];
				default: ;
			endcase
		endfunction

		// Percent of v in t, floored and capped at full scale; a zero total gives full scale, or zero when v is zero too.
		function logic [63:0] percent(logic [63:0] v, logic [63:0] t);
			if (t == 0)
				return (v == 0) ? 64'd0 : 64'(PCT_FULL);
			if (v >= t)
				return 64'(PCT_FULL);
			return (v * 64'(PCT_FULL)) / t;
		endfunction

		function logic [63:0] load_pct(logic [30:0] ld);
			if (cluster.load_peak < 31'(LOAD_PEAK_MIN))
				return percent(64'(ld), 64'(FIXED_LOAD_DIV));
			return percent(64'(ld), 64'(cluster.load_peak));
		endfunction

		function bit below_average(item_t it);
			logic [63:0] avg_load, avg_used;
			if (!it.server_alive || cluster.alive_count == 0)
				return 0;
			avg_load = 64'(cluster.load_sum) / 64'(cluster.alive_count);
			avg_used = 64'(cluster.capacity_sum) / 64'(cluster.alive_count);
			return (64'(it.server_load) < avg_load * 2 || cluster.load_sum == 0) &&
				(64'(it.server_used) <= avg_used * 2 || cluster.capacity_sum == 0);
		endfunction

		function void note_item(item_t it);
			result_t r;
			logic [63:0] w, e, u;
			r = '0;
			r.eligible = 1'b1;
			w = 0;
			if (it.req_type == REQ_SOURCE || it.req_type == REQ_SPARE) begin
				w = load_pct(it.server_load);
			end else if (it.server_full || !below_average(it)) begin
				r.eligible = 1'b0;
			end else if (it.req_type == REQ_WRITE) begin
				w = 64'(it.server_elections);
			end else begin
				e = percent(64'(it.server_elections), 64'(cluster.total_elect_num));
				u = (cluster.max_block_count == 0)
					? percent(64'(it.server_used), 64'(it.server_capacity))
					: percent(64'(it.server_blocks), 64'(cluster.max_block_count));
				w = e * W_ELECT + u * W_USE + load_pct(it.server_load) * W_LOAD;
			end
			r.weight = w[47:0];
			predicted_q.insert(predicted_q.size(), r);
		endfunction

		task check_result(result_t got);
			result_t exp_r;
			if (predicted_q.size() == 0) begin
				report_mismatch("result beat with no prediction waiting");
				return;
			end
			exp_r = predicted_q.pop_front();
			if (got.weight !== exp_r.weight)
				report_mismatch($sformatf("weight got %0d want %0d", got.weight, exp_r.weight));
			if (got.eligible !== exp_r.eligible)
				report_mismatch($sformatf("eligible got %0b want %0b",
					got.eligible, exp_r.eligible));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	item_t item = '0;
	logic empty;
	logic pop = 0;
	result_t result;
	logic cfg_we = 0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	server_placement_weight dut (.*);

	always #5 clk = ~clk;

	weight_scoreboard board = new();

	// Idle percentages of each side, changed by phase; hold_off forces a long receiver stall.
	int send_idle_pct = 30;
	int recv_idle_pct = 60;
	bit hold_off = 0;
	bit stim_done = 0;

	// Result side: sample at the rising edge, change pop at the falling edge.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			board.check_result(result);
	end

	always @(negedge clk) begin
		if (!arst_n || hold_off)
			pop <= 0;
		else
			pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Sends one record: raised at a falling edge, held until an edge accepts it.
	// Push stays high afterwards so that the next record can follow directly.
	task automatic send_record(item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 0;
			@(negedge clk);
		end
		push <= 1;
		item <= it;
		do
			@(posedge clk);
		while (full);
		board.note_item(it);
		@(negedge clk);
	endtask

	// Waits until every predicted beat has come, then lets the pipeline drain.
	task automatic drain();
		push <= 0;
		while (board.predicted_q.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		board.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic write_cluster(cfg_t c);
		write_reg(CFG_ALIVE_COUNT, 50'(c.alive_count));
		write_reg(CFG_LOAD_SUM, 50'(c.load_sum));
		write_reg(CFG_CAPACITY_SUM, 50'(c.capacity_sum));
		write_reg(CFG_MAX_BLOCK_COUNT, 50'(c.max_block_count));
		write_reg(CFG_LOAD_PEAK, 50'(c.load_peak));
		write_reg(CFG_TOTAL_ELECT_NUM, 50'(c.total_elect_num));
		cfg_we <= 0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Random value of a given width, biased toward small values, zero and all ones.
	function automatic logic [63:0] rand_width(int w);
		logic [63:0] m;
		m = (64'd1 << w) - 1;
		case ($urandom_range(5))
			0: return 0;
			1: return m;
			2: return 64'($urandom_range(20000));
			3: return rand64() & ((64'd1 << $urandom_range(w, 1)) - 1);
			default: return rand64() & m;
		endcase
	endfunction

	function automatic cfg_t random_cluster();
		cfg_t c;
		c.alive_count = 16'($urandom_range(9) == 0 ? 0 : rand_width(16));
		if ($urandom_range(3) == 0)
			c.alive_count = 16'($urandom_range(8, 1));
		c.load_sum = 31'(rand_width(31));
		c.capacity_sum = 50'(rand_width(50));
		c.max_block_count = 31'(rand_width(31));
		c.load_peak = 31'($urandom_range(3) == 0 ? $urandom_range(12) : rand_width(31));
		c.total_elect_num = 48'(rand_width(48));
		return c;
	endfunction

	// Mostly live, roughly average servers so that the weight paths are reached.
	function automatic item_t random_record();
		item_t it;
		logic [63:0] avg;
		it.req_type = 2'($urandom_range(3));
		it.server_alive = ($urandom_range(9) != 0);
		it.server_full = ($urandom_range(5) == 0);
		it.server_load = 31'(rand_width(31));
		it.server_used = 50'(rand_width(50));
		it.server_capacity = 50'(rand_width(50));
		it.server_blocks = 31'(rand_width(31));
		it.server_elections = 48'(rand_width(48));
		if (board.cluster.alive_count != 0 && $urandom_range(1)) begin
			avg = 64'(board.cluster.load_sum) / 64'(board.cluster.alive_count);
			it.server_load = 31'(rand64() % (avg * 2 + 2));
			avg = 64'(board.cluster.capacity_sum) / 64'(board.cluster.alive_count);
			it.server_used = 50'(rand64() % (avg * 2 + 2));
		end
		return it;
	endfunction

	task automatic run_random(int count);
		repeat (count) send_record(random_record());
	endtask

	initial begin
		cfg_t c;
		item_t it;
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed part: reset registers, then mid and extreme clusters.
		for (int m = 0; m < 4; m++) begin
			it = '0;
			it.req_type = 2'(m);
			send_record(it);
		end
		drain();
		c.alive_count = 4;
		c.load_sum = 4000;
		c.capacity_sum = 400000;
		c.max_block_count = 0;
		c.load_peak = 5;
		c.total_elect_num = 1000;
		write_cluster(c);
		for (int m = 0; m < 4; m++) begin
			it = '0;
			it.req_type = 2'(m);
			it.server_alive = 1;
			it.server_load = 1999;
			it.server_used = 200000;
			it.server_capacity = 300000;
			it.server_elections = 250;
			send_record(it);
			it.server_load = 2000;
			send_record(it);
			it.server_load = 10;
			it.server_used = 200001;
			send_record(it);
			it.server_used = 5;
			it.server_full = 1;
			send_record(it);
		end
		drain();
		c.alive_count = 16'hFFFF;
		c.load_sum = '1;
		c.capacity_sum = '1;
		c.max_block_count = '1;
		c.load_peak = '1;
		c.total_elect_num = '1;
		write_cluster(c);
		it = '1;
		it.req_type = REQ_DEST;
		it.server_full = 0;
		send_record(it);
		it.server_load = 0;
		it.server_used = 0;
		send_record(it);
		it.req_type = REQ_WRITE;
		send_record(it);
		it = '1;
		it.req_type = REQ_SOURCE;
		send_record(it);
		drain();

		// Random phases, each under a fresh cluster setting.
		for (int p = 0; p < 15; p++) begin
			if (p == 5) begin
				send_idle_pct = 60;
				recv_idle_pct = 30;
			end else if (p == 10) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_cluster(random_cluster());
			if (p == 12) begin
				// Long receiver stall while the sender keeps pushing.
				hold_off = 1;
				fork
					begin
						repeat (300) @(negedge clk);
						hold_off = 0;
					end
					run_random(110);
				join
			end else begin
				run_random(110);
			end
			drain();
		end
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
